[rtl/core/first_fit_block_allocator_top_defines.svh]
// Assertion macros for the first-fit block allocator.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define FFBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ffba assertion failed");
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ffba assertion failed");
`else
`define FFBA_ASSERT_NOW(label, clk, rst, ante, cons)
`define FFBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/ffba_pkg.sv]
// Types and constants of the first-fit block allocator.
package ffba_pkg;
   localparam int MAX_BLOCKS_DEF   = 64;
   localparam int HEADER_BYTES_DEF = 16;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NONE    = 3'd1;
   localparam logic [2:0] ST_LIMIT   = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic CSR_HEAP_BASE  = 1'b0;
   localparam logic CSR_HEAP_LIMIT = 1'b1;

   localparam logic [31:0] HEAP_LIMIT_RST = 32'd65536;

   typedef struct packed {
      logic        free;
      logic [23:0] bytes;
      logic [31:0] start;
   } entry_type;
endpackage

[rtl/core/first_fit_block_allocator_top.sv]
// First-fit heap allocator with a block table in one synchronous memory.
//
// Requests enter on req_*: req_tuser selects allocate or free, req_tdata carries
// the size and the payload address. One response per request leaves on rsp_*.
// The block handles one request at a time: the scan reads table entries in order
// until a match or the end of the table (none for a null request or an empty table,
// at most MAX_BLOCKS). The table memory has a single read port, which the scan
// visits one entry per cycle; each read is registered before it is compared.
// The response sits in an output register; req_tready returns high as soon as
// the response is loaded, so the next request may enter while it waits.
// If rsp_tready stays low, the following request finishes its scan and holds
// until the output register frees.
// Reset (synchronous, active high) empties the table, zeroes the heap top and
// loads heap_base 0 and heap_limit 65536; the memory itself is not cleared.
// csr_* writes heap_base (index 0) or heap_limit (index 1); write
// only while no request is in flight.
module first_fit_block_allocator_top
   import ffba_pkg::*;
#(
   parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // [23:0] req_size, [55:24] addr
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_addr
   output logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
`include "first_fit_block_allocator_top_defines.svh"

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   entry_type mem [MAX_BLOCKS];
   entry_type mem_q;

   logic [1:0]       state_ff, state_in;
   logic [31:0]      heap_base_ff, heap_limit_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      top_ff, top_in;
   logic [CNT_W-1:0] iss_ff, iss_in;
   logic [CNT_W-1:0] rtag_ff, rtag_in;
   logic             rvalid_ff, rvalid_in;
   logic             func_ff;
   logic [23:0]      size_ff;
   logic [31:0]      addr_ff;
   logic [31:0]      target_ff;
   logic [32:0]      end_ff;
   logic [31:0]      res_addr_ff, res_addr_in;
   logic [2:0]       res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_addr_ff;
   logic [2:0]       rsp_status_ff;

   logic             rd_en;
   logic [IDX_W-1:0] rd_idx;
   logic             wr_en;
   logic [IDX_W-1:0] wr_idx;
   entry_type        wr_data;

   logic req_fire, null_req, hit, last_tag, miss, out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign null_req = (func_ff == FUNC_FREE) ? (addr_ff == 32'd0) : (size_ff == 24'd0);
   assign hit      = (func_ff == FUNC_FREE) ? (mem_q.start == target_ff)
                                            : (mem_q.free && (mem_q.bytes >= size_ff));
   assign last_tag = ((rtag_ff + CNT_W'(1)) == count_ff);
   assign miss     = (count_ff == '0) || (rvalid_ff && !hit && last_tag);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      iss_in        = iss_ff;
      rtag_in       = rtag_ff;
      rvalid_in     = 1'b0;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rd_en         = 1'b0;
      rd_idx        = iss_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_idx        = rtag_ff[IDX_W-1:0];
      wr_data       = mem_q;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_SCAN;
               iss_in   = '0;
            end
         end
         S_SCAN: begin
            if (null_req) begin
               res_addr_in   = 32'd0;
               res_status_in = ST_NONE;
               state_in      = S_DONE;
            end else if (miss) begin
               res_addr_in = 32'd0;
               state_in    = S_DONE;
               if (func_ff == FUNC_FREE) begin
                  res_status_in = ST_UNKNOWN;
               end else if (end_ff > {1'b0, heap_limit_ff}) begin
                  res_status_in = ST_LIMIT;
               end else if (count_ff == CNT_W'(MAX_BLOCKS)) begin
                  res_status_in = ST_FULL;
               end else begin
                  wr_en         = 1'b1;
                  wr_idx        = count_ff[IDX_W-1:0];
                  wr_data.free  = 1'b0;
                  wr_data.bytes = size_ff;
                  wr_data.start = top_ff;
                  count_in      = count_ff + CNT_W'(1);
                  top_in        = end_ff[31:0];
                  res_addr_in   = heap_base_ff + top_ff + 32'(HEADER_BYTES);
                  res_status_in = ST_OK;
               end
            end else if (rvalid_ff && hit) begin
               state_in      = S_DONE;
               res_status_in = ST_OK;
               if (func_ff == FUNC_FREE) begin
                  res_addr_in = 32'd0;
                  if (last_tag) begin
                     count_in = rtag_ff;
                     top_in   = mem_q.start;
                  end else begin
                     wr_en        = 1'b1;
                     wr_data.free = 1'b1;
                  end
               end else begin
                  wr_en        = 1'b1;
                  wr_data.free = 1'b0;
                  res_addr_in  = heap_base_ff + mem_q.start + 32'(HEADER_BYTES);
               end
            end else if (iss_ff < count_ff) begin
               rd_en     = 1'b1;
               rvalid_in = 1'b1;
               rtag_in   = iss_ff;
               iss_in    = iss_ff + CNT_W'(1);
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q <= mem[rd_idx];
      end
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         heap_base_ff  <= 32'd0;
         heap_limit_ff <= HEAP_LIMIT_RST;
         count_ff      <= '0;
         top_ff        <= 32'd0;
         rvalid_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         rvalid_ff    <= rvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_HEAP_BASE:  heap_base_ff  <= csr_wdata;
               CSR_HEAP_LIMIT: heap_limit_ff <= csr_wdata;
               default:        heap_base_ff  <= heap_base_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      iss_ff        <= iss_in;
      rtag_ff       <= rtag_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      if (req_fire) begin
         func_ff   <= req_tuser;
         size_ff   <= req_tdata[23:0];
         addr_ff   <= req_tdata[55:24];
         target_ff <= req_tdata[55:24] - heap_base_ff - 32'(HEADER_BYTES);
         end_ff    <= {1'b0, top_ff} + 33'(HEADER_BYTES) + {9'd0, req_tdata[23:0]};
      end
      if ((state_ff == S_DONE) && out_free) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

   `FFBA_ASSERT_NEXT(a_accept_scans, clock, reset, req_fire, state_ff == S_SCAN)
   `FFBA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_BLOCKS))
   `FFBA_ASSERT_NOW(a_read_in_scan, clock, reset, rvalid_ff, state_ff == S_SCAN)
   `FFBA_ASSERT_NOW(a_write_in_scan, clock, reset, wr_en, state_ff == S_SCAN && !rd_en)
endmodule

[tb/testbench.sv]
// Self-checking testbench for the first-fit block allocator.
module testbench
   import ffba_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES    = 600;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_ITEMS    = 110;

   typedef struct packed {
      logic [31:0] result_addr;
      logic [2:0]  status;
   } response_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [55:0] req_tdata  = '0;
   logic        req_tuser  = FUNC_ALLOC;
   logic        rsp_tready = 1'b1;
   logic        csr_we     = 1'b0;
   logic        csr_index  = CSR_HEAP_BASE;
   logic [31:0] csr_wdata  = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   logic [31:0] tbl_start [MAX_BLOCKS_DEF];
   logic [23:0] tbl_bytes [MAX_BLOCKS_DEF];
   logic        tbl_free  [MAX_BLOCKS_DEF];
   int          tbl_count = 0;
   logic [31:0] brk_top   = '0;
   logic [31:0] cfg_base  = '0;
   logic [31:0] cfg_limit = HEAP_LIMIT_RST;

   response_type pending_responses[$];
   int        error_count   = 0;
   int        idle_cycles   = 0;
   bit        send_gaps     = 1'b1;
   bit        rsp_gaps      = 1'b1;
   bit        hold_request  = 1'b0;

   first_fit_block_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] payload_addr(int idx);
      return cfg_base + tbl_start[idx] + 32'(HEADER_BYTES_DEF);
   endfunction

   function automatic response_type allocator_step(logic fn, logic [23:0] sz, logic [31:0] ad);
      response_type r;
      logic [32:0]  end_off;
      int           hit;
      int           i;
      r.result_addr = '0;
      r.status = ST_OK;
      hit = -1;
      if (fn == FUNC_ALLOC) begin
         if (sz == '0) begin
            r.status = ST_NONE;
         end else begin
            for (i = 0; i < tbl_count; i++)
               if (hit < 0 && tbl_free[i] && tbl_bytes[i] >= sz) hit = i;
            if (hit >= 0) begin
               tbl_free[hit] = 1'b0;
               r.result_addr = payload_addr(hit);
            end else begin
               end_off = {1'b0, brk_top} + 33'(HEADER_BYTES_DEF) + 33'(sz);
               if (end_off > {1'b0, cfg_limit}) begin
                  r.status = ST_LIMIT;
               end else if (tbl_count >= MAX_BLOCKS_DEF) begin
                  r.status = ST_FULL;
               end else begin
                  tbl_start[tbl_count] = brk_top;
                  tbl_bytes[tbl_count] = sz;
                  tbl_free[tbl_count] = 1'b0;
                  r.result_addr = payload_addr(tbl_count);
                  tbl_count++;
                  brk_top = end_off[31:0];
               end
            end
         end
      end else if (ad == '0) begin
         r.status = ST_NONE;
      end else begin
         for (i = 0; i < tbl_count; i++)
            if (hit < 0 && payload_addr(i) == ad) hit = i;
         if (hit < 0) begin
            r.status = ST_UNKNOWN;
         end else if (hit == tbl_count - 1) begin
            brk_top = tbl_start[hit];
            tbl_count = hit;
         end else begin
            tbl_free[hit] = 1'b1;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic send_request(input logic fn, input logic [23:0] sz, input logic [31:0] ad);
      int gap;
      gap = send_gaps ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= fn;
      req_tdata <= {ad, sz};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_responses.push_back(allocator_step(fn, sz, ad));
   endtask

   task automatic drain_requests();
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_HEAP_BASE) cfg_base = val;
      else cfg_limit = val;
      @(posedge clock);
   endtask

   task automatic random_request();
      logic        fn;
      logic [23:0] sz;
      logic [31:0] ad;
      int          pick;
      int          j;
      pick = $urandom_range(0, 99);
      sz = 24'($urandom);
      ad = $urandom;
      if (pick < 45) begin
         fn = FUNC_ALLOC;
         j = $urandom_range(0, 9);
         if (j == 0) sz = '0;
         else if (j < 5 && tbl_count > 0) sz = tbl_bytes[$urandom_range(0, tbl_count - 1)];
         else if (j > 1) sz = 24'($urandom_range(1, 300));
      end else if (pick < 90) begin
         fn = FUNC_FREE;
         if (tbl_count > 0) begin
            if ($urandom_range(0, 9) < 4) ad = payload_addr(tbl_count - 1);
            else ad = payload_addr($urandom_range(0, tbl_count - 1));
         end
      end else begin
         fn = FUNC_FREE;
         j = $urandom_range(0, 2);
         if (j == 0) ad = '0;
         else if (j == 2 && tbl_count > 0)
            ad = payload_addr($urandom_range(0, tbl_count - 1)) + $urandom_range(1, 15);
      end
      send_request(fn, sz, ad);
   endtask

   task automatic test_directed();
      logic [31:0] popped;
      send_request(FUNC_ALLOC, 24'd0, 32'd0);
      send_request(FUNC_FREE, 24'hFF_FFFF, 32'd0);
      send_request(FUNC_ALLOC, 24'hFF_FFFF, 32'hFFFF_FFFF);
      send_request(FUNC_ALLOC, 24'd1, 32'd0);
      send_request(FUNC_ALLOC, 24'd100, 32'd0);
      send_request(FUNC_ALLOC, 24'd50, 32'd0);
      send_request(FUNC_FREE, 24'd0, payload_addr(1));
      send_request(FUNC_FREE, 24'd0, payload_addr(1));
      send_request(FUNC_ALLOC, 24'd80, 32'd0);
      send_request(FUNC_FREE, 24'd0, payload_addr(2) + 32'd1);
      send_request(FUNC_FREE, 24'd0, 32'hFFFF_FFFF);
      popped = payload_addr(2);
      send_request(FUNC_FREE, 24'd0, popped);
      send_request(FUNC_FREE, 24'd0, popped);
      send_request(FUNC_FREE, 24'd0, payload_addr(0));
      send_request(FUNC_FREE, 24'd0, payload_addr(1));
      send_request(FUNC_ALLOC, 24'd1, 32'd0);
      send_request(FUNC_FREE, 24'd0, payload_addr(0));
   endtask

   task automatic test_table_full();
      drain_requests();
      csr_write(CSR_HEAP_LIMIT, 32'hFFFF_FFFF);
      while (tbl_count < MAX_BLOCKS_DEF)
         send_request(FUNC_ALLOC, 24'($urandom_range(1, 64)), $urandom);
      send_request(FUNC_ALLOC, 24'd5, $urandom);
      send_request(FUNC_FREE, 24'($urandom), payload_addr(tbl_count - 1));
      drain_requests();
      csr_write(CSR_HEAP_LIMIT, brk_top + 32'(HEADER_BYTES_DEF) + 32'd9);
      send_request(FUNC_ALLOC, 24'd10, $urandom);
      send_request(FUNC_ALLOC, 24'd9, $urandom);
      send_request(FUNC_ALLOC, 24'd1, $urandom);
      while (tbl_count > 0)
         send_request(FUNC_FREE, 24'($urandom), payload_addr(tbl_count - 1));
      drain_requests();
      csr_write(CSR_HEAP_LIMIT, HEAP_LIMIT_RST);
   endtask

   task automatic test_base_moves();
      logic [31:0] stale;
      drain_requests();
      csr_write(CSR_HEAP_BASE, 32'hFFFF_FFF8);
      repeat (3) send_request(FUNC_ALLOC, 24'($urandom_range(1, 40)), $urandom);
      drain_requests();
      stale = payload_addr(1);
      csr_write(CSR_HEAP_BASE, 32'h1000_0000);
      send_request(FUNC_FREE, 24'($urandom), stale);
      send_request(FUNC_FREE, 24'($urandom), payload_addr(1));
      drain_requests();
      csr_write(CSR_HEAP_LIMIT, 32'd0);
      send_request(FUNC_ALLOC, 24'd1, $urandom);
      send_request(FUNC_ALLOC, 24'd1, $urandom);
      while (tbl_count > 0)
         send_request(FUNC_FREE, 24'($urandom), payload_addr(tbl_count - 1));
      drain_requests();
      csr_write(CSR_HEAP_BASE, 32'hFFFF_FFFF);
      csr_write(CSR_HEAP_LIMIT, HEAP_LIMIT_RST);
   endtask

   task automatic test_backpressure();
      send_gaps = 1'b0;
      hold_request = 1'b1;
      repeat (8) send_request(FUNC_ALLOC, 24'($urandom_range(1, 200)), $urandom);
      drain_requests();
      send_gaps = 1'b1;
   endtask

   task automatic test_random_phases();
      int p;
      logic [31:0] base_val;
      logic [31:0] limit_val;
      for (p = 0; p < RANDOM_PHASES; p++) begin
         drain_requests();
         case (p % 3)
            0: base_val = 32'd0;
            1: base_val = 32'hFFFF_FFFF;
            default: base_val = $urandom;
         endcase
         case (p % 5)
            0: limit_val = HEAP_LIMIT_RST;
            1: limit_val = 32'd0;
            2: limit_val = 32'hFFFF_FFFF;
            3: limit_val = $urandom_range(0, 4000);
            default: limit_val = $urandom;
         endcase
         csr_write(CSR_HEAP_BASE, base_val);
         csr_write(CSR_HEAP_LIMIT, limit_val);
         send_gaps = (p % 3) != 2;
         rsp_gaps = (p % 2) == 0;
         repeat (PHASE_ITEMS) random_request();
      end
   endtask

   initial begin : receiver
      int stall;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (rsp_tvalid && rsp_tready) begin
            stall = rsp_gaps ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_tready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      response_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_responses.size() == 0) begin
            report_mismatch($sformatf("unexpected response addr %h status %0d",
                                      rsp_tdata, rsp_tuser));
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tdata !== want.result_addr)
               report_mismatch($sformatf("result_addr %h, predicted %h",
                                         rsp_tdata, want.result_addr));
            if (rsp_tuser !== want.status)
               report_mismatch($sformatf("status %0d, predicted %0d",
                                         rsp_tuser, want.status));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_table_full();
      test_base_moves();
      test_backpressure();
      test_random_phases();
      drain_requests();
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
